// ===== design/gcr_pkg.sv =====
// ----------------------------------------------------------------------------
// gcr_pkg
// Shared types, register codes and constant functions of the color ramp
// generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gcr_pkg;

	// field widths fixed by the request and result formats
	localparam int GAMMA_BITS     = 16;
	localparam int COUNT_BITS     = 7;
	localparam int COMP_BITS      = 8;
	localparam int CFG_INDEX_BITS = 3;

	// gamma floor of 0.05 in 4.12 fixed point, and 1.0 as a shift
	localparam logic [GAMMA_BITS-1:0] GAMMA_FLOOR = 16'd205;
	localparam int GAMMA_ONE_SHIFT = 12;

	// queue between front and back
	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_PTR   = 2;

	// register indexes of the configuration port
	localparam logic [CFG_INDEX_BITS-1:0] REG_BRIGHT_RED   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BRIGHT_GREEN = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_BRIGHT_BLUE  = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DARK_RED     = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DARK_GREEN   = 3'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DARK_BLUE    = 3'd5;

	// ramp end colors handed to the back end
	typedef struct packed {
		logic [COMP_BITS-1:0] bright_red;
		logic [COMP_BITS-1:0] bright_green;
		logic [COMP_BITS-1:0] bright_blue;
		logic [COMP_BITS-1:0] dark_red;
		logic [COMP_BITS-1:0] dark_green;
		logic [COMP_BITS-1:0] dark_blue;
	} color_cfg_t;

	// floor square root of a 64-bit value, elaboration only
	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		v   = val;
		res = '0;
		bt  = 64'd1 << 62;
		for (int s = 0; s < 32; s++) begin
			if (v >= res + bt) begin
				v   = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// 2^(-2^-k) in Q32, built by k floor square roots of 0.5
	function automatic logic [31:0] exp_root(input int k);
		logic [63:0] r;
		r = 64'd1 << 31;
		for (int j = 1; j <= 24; j++) begin
			if (j <= k) begin
				r = isqrt64(r << 32);
			end
		end
		return r[31:0];
	endfunction

endpackage

// ===== design/gcr_log2.sv =====
// ----------------------------------------------------------------------------
// gcr_log2
// Bit-serial log2 of a small integer: one squaring per fraction bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcr_log2 #(
	parameter int XW = 6,
	parameter int F  = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [XW-1:0]   x,
	output logic            busy,
	output logic [XW+F-1:0] result
);

	localparam int CB = $clog2(F + 1);

	logic [XW-1:0]   e_c;
	logic [XW-1:0]   e_q;
	logic [XW+F-1:0] xs_c;
	logic [F:0]      m_q;
	logic [2*F+1:0]  sq_c;
	logic [F+1:0]    sh_c;
	logic [F-1:0]    frac_q;
	logic [CB-1:0]   cnt_q;
	logic            busy_q;

	// position of the top set bit
	always_comb begin
		e_c = '0;
		for (int b = 0; b < XW; b++) begin
			if (x[b]) begin
				e_c = XW'(b);
			end
		end
	end

	// mantissa in [1,2) and its square
	assign xs_c = {x, {F{1'b0}}} >> e_c;
	assign sq_c = (2*F+2)'(m_q) * (2*F+2)'(m_q);
	assign sh_c = sq_c[2*F+1:F];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CB'(F - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			e_q <= e_c;
			m_q <= xs_c[F:0];
		end else if (busy_q) begin
			if (sh_c[F+1]) begin
				m_q    <= sh_c[F+1:1];
				frac_q <= {frac_q[F-2:0], 1'b1};
			end else begin
				m_q    <= sh_c[F:0];
				frac_q <= {frac_q[F-2:0], 1'b0};
			end
		end
	end

	assign busy   = busy_q;
	assign result = {e_q, frac_q};

endmodule

// ===== design/gcr_front.sv =====
// ----------------------------------------------------------------------------
// gcr_front
// Takes a request, clamps it, divides out 1/gamma, takes log2(count-1)
// and emits one work entry per ramp step into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcr_front #(
	parameter int MAX_ENTRIES   = 64,
	parameter int INDEX_BITS    = 12,
	parameter int FRACTION_BITS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [gcr_pkg::GAMMA_BITS-1:0]   gamma_value,
	input  logic [INDEX_BITS-1:0]            first_index,
	input  logic [gcr_pkg::COUNT_BITS-1:0]   entry_count,
	output logic                             q_valid,
	input  logic                             q_ready,
	output logic [INDEX_BITS+1+2*$clog2(MAX_ENTRIES)+2*FRACTION_BITS+3:0] q_data
);

	localparam int F   = FRACTION_BITS;
	localparam int IW  = $clog2(MAX_ENTRIES);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int LW  = IW + F;
	localparam int VW  = F + 4;
	localparam int DW  = gcr_pkg::GAMMA_ONE_SHIFT + 1 + F;
	localparam int DCB = $clog2(DW + 1);
	localparam logic [DW-1:0] VMAX = DW'({VW{1'b1}});

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                        state_q;
	logic [gcr_pkg::GAMMA_BITS-1:0]    g_q;
	logic [gcr_pkg::GAMMA_BITS-1:0]    g_c;
	logic [CW-1:0]                     cnt_c;
	logic [CW-1:0]                     count_q;
	logic [INDEX_BITS-1:0]             base_q;
	logic [gcr_pkg::GAMMA_BITS-1:0]    rem_q;
	logic [gcr_pkg::GAMMA_BITS:0]      rem2_c;
	logic [DW-1:0]                     quo_q;
	logic [DCB-1:0]                    dcnt_q;
	logic [IW-1:0]                     i_q;
	logic [VW-1:0]                     inv_c;
	logic [LW-1:0]                     logn;
	logic                              log_busy;
	logic                              accept;
	logic                              last_c;
	logic                              div_done;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);

	// request clamps
	assign g_c   = (gamma_value < gcr_pkg::GAMMA_FLOOR) ? gcr_pkg::GAMMA_FLOOR : gamma_value;
	assign cnt_c = (entry_count > gcr_pkg::COUNT_BITS'(MAX_ENTRIES)) ?
		CW'(MAX_ENTRIES) : CW'(entry_count);

	// restoring divider step; the dividend has a single set bit at the top
	assign rem2_c   = {rem_q, (dcnt_q == '0)};
	assign div_done = (dcnt_q == DCB'(DW));
	assign inv_c    = (quo_q > VMAX) ? VW'(VMAX) : quo_q[VW-1:0];

	gcr_log2 #(
		.XW(IW),
		.F (F)
	) u_log_n (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.x     (IW'(cnt_c - 1'b1)),
		.busy  (log_busy),
		.result(logn)
	);

	// entry word
	assign last_c  = (CW'(i_q) + 1'b1 == count_q);
	assign q_valid = (state_q == ST_EMIT);
	assign q_data  = {base_q + INDEX_BITS'(i_q), last_c, i_q, logn, inv_c};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dcnt_q  <= '0;
			i_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_DIV;
						dcnt_q  <= '0;
						i_q     <= '0;
					end
				end
				ST_DIV: begin
					if (!div_done) begin
						dcnt_q <= dcnt_q + 1'b1;
					end else if (!log_busy) begin
						state_q <= (count_q == '0) ? ST_IDLE : ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (q_ready) begin
						if (last_c) begin
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request and divider datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			g_q     <= g_c;
			count_q <= cnt_c;
			base_q  <= first_index;
			rem_q   <= '0;
			quo_q   <= '0;
		end else if (state_q == ST_DIV && !div_done) begin
			if (rem2_c >= {1'b0, g_q}) begin
				rem_q <= gcr_pkg::GAMMA_BITS'(rem2_c - {1'b0, g_q});
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= rem2_c[gcr_pkg::GAMMA_BITS-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

endmodule

// ===== design/gcr_queue.sv =====
// ----------------------------------------------------------------------------
// gcr_queue
// Short register queue that decouples the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcr_queue #(
	parameter int W = 72
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  logic [W-1:0] in_data,
	output logic         out_valid,
	input  logic         out_ready,
	output logic [W-1:0] out_data
);

	localparam int PW = gcr_pkg::QUEUE_PTR;

	logic [W-1:0]  mem_q [gcr_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [PW:0]   cnt_q;
	logic          push;
	logic          pop;

	assign in_ready  = (cnt_q != (PW+1)'(gcr_pkg::QUEUE_DEPTH));
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_data  = mem_q[rd_q];

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

endmodule

// ===== design/gcr_back.sv =====
// ----------------------------------------------------------------------------
// gcr_back
// Per entry: log2(i), scale by 1/gamma, serial exp2 and color blend into
// the output register; entry 0 goes straight to the blend.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcr_back #(
	parameter int MAX_ENTRIES   = 64,
	parameter int INDEX_BITS    = 12,
	parameter int FRACTION_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            q_valid,
	output logic                            q_ready,
	input  logic [INDEX_BITS+1+2*$clog2(MAX_ENTRIES)+2*FRACTION_BITS+3:0] q_data,
	input  gcr_pkg::color_cfg_t             cfg,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [INDEX_BITS-1:0]           map_index,
	output logic [gcr_pkg::COMP_BITS-1:0]   red_out,
	output logic [gcr_pkg::COMP_BITS-1:0]   green_out,
	output logic [gcr_pkg::COMP_BITS-1:0]   blue_out,
	output logic                            last_entry
);

	localparam int F  = FRACTION_BITS;
	localparam int IW = $clog2(MAX_ENTRIES);
	localparam int LW = IW + F;
	localparam int VW = F + 4;
	localparam int PW = LW + VW - F;
	localparam int QW = PW - F;
	localparam int KB = $clog2(F);
	localparam int CB = gcr_pkg::COMP_BITS;
	localparam logic [F+CB:0] MASK = (F+CB+1)'({F{1'b1}});

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_LOG   = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_EXP   = 3'd3;
	localparam logic [2:0] ST_SHIFT = 3'd4;
	localparam logic [2:0] ST_BLEND = 3'd5;

	logic [2:0]            state_q;
	logic [INDEX_BITS-1:0] e_index;
	logic                  e_last;
	logic [IW-1:0]         e_i;
	logic [LW-1:0]         e_logn;
	logic [VW-1:0]         e_inv;
	logic [INDEX_BITS-1:0] idx_q;
	logic                  last_q;
	logic [LW-1:0]         logn_q;
	logic [VW-1:0]         inv_q;
	logic [LW-1:0]         logi;
	logic                  log_busy;
	logic                  log_start;
	logic [LW-1:0]         d_c;
	logic [LW+VW-1:0]      prod_c;
	logic [PW-1:0]         p_q;
	logic [F-1:0]          fsh_q;
	logic [KB-1:0]         k_q;
	logic [32:0]           acc_q;
	logic [64:0]           acc_mul;
	logic [31:0]           root_tab [F];
	logic [QW:0]           qx_c;
	logic [32:0]           accsh_c;
	logic [F:0]            y_q;
	logic                  out_free;
	logic                  m_tvalid_q;

	// root table, one constant per exp2 step
	for (genvar gk = 0; gk < F; gk++) begin : g_root
		assign root_tab[gk] = gcr_pkg::exp_root(gk + 1);
	end

	function automatic logic [CB-1:0] blend(input logic [CB-1:0] dk,
			input logic [CB-1:0] br, input logic [F:0] yv);
		logic [F+CB:0] prod;
		if (br >= dk) begin
			prod = (F+CB+1)'(yv) * (F+CB+1)'(br - dk);
			return dk + prod[F+CB-1:F];
		end
		prod = (F+CB+1)'(yv) * (F+CB+1)'(dk - br) + MASK;
		return dk - prod[F+CB-1:F];
	endfunction

	assign {e_index, e_last, e_i, e_logn, e_inv} = q_data;
	assign q_ready   = (state_q == ST_IDLE);
	assign log_start = (state_q == ST_IDLE) && q_valid && (e_i != '0);

	gcr_log2 #(
		.XW(IW),
		.F (F)
	) u_log_i (
		.clk   (clk),
		.arst_n(arst_n),
		.start (log_start),
		.x     (e_i),
		.busy  (log_busy),
		.result(logi)
	);

	// log difference scaled by 1/gamma
	assign d_c    = logn_q - logi;
	assign prod_c = (LW+VW)'(d_c) * (LW+VW)'(inv_q);

	// exp2 step and final shift by the integer part
	assign acc_mul = 65'(acc_q) * 65'(root_tab[k_q]);
	assign qx_c    = {1'b0, p_q[PW-1:F]};
	assign accsh_c = acc_q >> qx_c;

	assign out_free = !m_tvalid_q || m_tready;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						state_q <= (e_i == '0) ? ST_BLEND : ST_LOG;
					end
				end
				ST_LOG: begin
					if (!log_busy) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_EXP;
					k_q     <= '0;
				end
				ST_EXP: begin
					k_q <= k_q + 1'b1;
					if (k_q == KB'(F - 1)) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: state_q <= ST_BLEND;
				ST_BLEND: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// entry datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid) begin
			idx_q  <= e_index;
			last_q <= e_last;
			logn_q <= e_logn;
			inv_q  <= e_inv;
			y_q    <= '0;
		end
		if (state_q == ST_MUL) begin
			p_q   <= prod_c[LW+VW-1:F];
			fsh_q <= prod_c[2*F-1:F];
			acc_q <= 33'd1 << 32;
		end
		if (state_q == ST_EXP) begin
			fsh_q <= {fsh_q[F-2:0], 1'b0};
			if (fsh_q[F-1]) begin
				acc_q <= acc_mul[64:32];
			end
		end
		if (state_q == ST_SHIFT) begin
			y_q <= (qx_c > (QW+1)'(32)) ? '0 : accsh_c[32:32-F];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ST_BLEND && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_BLEND && out_free) begin
			map_index  <= idx_q;
			last_entry <= last_q;
			red_out    <= blend(cfg.dark_red, cfg.bright_red, y_q);
			green_out  <= blend(cfg.dark_green, cfg.bright_green, y_q);
			blue_out   <= blend(cfg.dark_blue, cfg.bright_blue, y_q);
		end
	end

	assign m_tvalid = m_tvalid_q;

endmodule

// ===== design/gamma_color_ramp_generator_top.sv =====
// ----------------------------------------------------------------------------
// gamma_color_ramp_generator_top
// Gamma-corrected color ramp: one color-map write beat per ramp entry.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    gamma_value, first_index, entry_count
//  m_*       out  m_tvalid/m_tready    map_index, red/green/blue, last (tlast)
//  cfg_*     in   cfg_valid/cfg_ready  cfg_index, cfg_data (ramp end colors)
//
//  Front: 13+FRACTION_BITS restoring steps per request divide out 1/gamma,
//  then one queue push per entry; takes the next request once all are pushed.
//  Back: per entry, serial log2 squarings, one scaling multiply, serial exp2
//  steps, shift and blend; entry 0 goes straight to the blend.
//  Reset is asynchronous and clears control and the color registers only;
//  no clearing pass.
//  A stalled output holds its beat while the back end works on the next one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gamma_color_ramp_generator_top #(
	parameter int MAX_ENTRIES   = 64,
	parameter int INDEX_BITS    = 12,
	parameter int FRACTION_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// gamma_value[15:0], first_index, entry_count[6:0], zero pad
	input  logic [((gcr_pkg::GAMMA_BITS+INDEX_BITS+gcr_pkg::COUNT_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// map_index, red_out[7:0], green_out[7:0], blue_out[7:0], zero pad
	output logic [((INDEX_BITS+3*gcr_pkg::COMP_BITS+7)/8)*8-1:0] m_tdata,
	output logic                                 m_tlast,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gcr_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
	input  logic [gcr_pkg::COMP_BITS-1:0]        cfg_data
);

	localparam int GB = gcr_pkg::GAMMA_BITS;
	localparam int NB = gcr_pkg::COUNT_BITS;
	localparam int CB = gcr_pkg::COMP_BITS;
	localparam int MP = ((INDEX_BITS+3*CB+7)/8)*8 - (INDEX_BITS+3*CB);
	localparam int EW = INDEX_BITS + 1 + 2*$clog2(MAX_ENTRIES) + 2*FRACTION_BITS + 4;

	gcr_pkg::color_cfg_t cfg_q;

	logic          fq_valid;
	logic          fq_ready;
	logic [EW-1:0] fq_data;
	logic          qb_valid;
	logic          qb_ready;
	logic [EW-1:0] qb_data;
	logic [INDEX_BITS-1:0] map_index;
	logic [CB-1:0] red_out;
	logic [CB-1:0] green_out;
	logic [CB-1:0] blue_out;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bright_red   <= 8'd255;
			cfg_q.bright_green <= 8'd255;
			cfg_q.bright_blue  <= 8'd255;
			cfg_q.dark_red     <= 8'd0;
			cfg_q.dark_green   <= 8'd0;
			cfg_q.dark_blue    <= 8'd0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gcr_pkg::REG_BRIGHT_RED:   cfg_q.bright_red   <= cfg_data;
				gcr_pkg::REG_BRIGHT_GREEN: cfg_q.bright_green <= cfg_data;
				gcr_pkg::REG_BRIGHT_BLUE:  cfg_q.bright_blue  <= cfg_data;
				gcr_pkg::REG_DARK_RED:     cfg_q.dark_red     <= cfg_data;
				gcr_pkg::REG_DARK_GREEN:   cfg_q.dark_green   <= cfg_data;
				gcr_pkg::REG_DARK_BLUE:    cfg_q.dark_blue    <= cfg_data;
				default: ;
			endcase
		end
	end

	gcr_front #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.INDEX_BITS   (INDEX_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.gamma_value(s_tdata[GB-1:0]),
		.first_index(s_tdata[GB+INDEX_BITS-1:GB]),
		.entry_count(s_tdata[GB+INDEX_BITS+NB-1:GB+INDEX_BITS]),
		.q_valid    (fq_valid),
		.q_ready    (fq_ready),
		.q_data     (fq_data)
	);

	gcr_queue #(
		.W(EW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fq_valid),
		.in_ready (fq_ready),
		.in_data  (fq_data),
		.out_valid(qb_valid),
		.out_ready(qb_ready),
		.out_data (qb_data)
	);

	gcr_back #(
		.MAX_ENTRIES  (MAX_ENTRIES),
		.INDEX_BITS   (INDEX_BITS),
		.FRACTION_BITS(FRACTION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (qb_valid),
		.q_ready   (qb_ready),
		.q_data    (qb_data),
		.cfg       (cfg_q),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.map_index (map_index),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.last_entry(m_tlast)
	);

	// output beat packing
	assign m_tdata = {{MP{1'b0}}, blue_out, green_out, red_out, map_index};

endmodule

// ===== design/gcr_checker.sv =====
// ----------------------------------------------------------------------------
// gcr_checker
// Port-level assertions for the color ramp generator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gcr_checker #(
	parameter int S_WIDTH = 40,
	parameter int M_WIDTH = 40
) (
	input logic               clk,
	input logic               arst_n,
	input logic               s_tvalid,
	input logic               s_tready,
	input logic [S_WIDTH-1:0] s_tdata,
	input logic               m_tvalid,
	input logic               m_tready,
	input logic [M_WIDTH-1:0] m_tdata,
	input logic               m_tlast,
	input logic               cfg_valid,
	input logic               cfg_ready
);

	// a request beat blocks the input while 1/gamma is divided out
	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
		else $error("input ready too soon after a request beat");

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled result beat changed");

	// configuration writes never stall
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write stalled");

endmodule

bind gamma_color_ramp_generator_top gcr_checker #(
	.S_WIDTH($bits(s_tdata)),
	.M_WIDTH($bits(m_tdata))
) u_gcr_checker (.*);

// ===== tb/gamma_color_ramp_generator_top_tb.sv =====
// ----------------------------------------------------------------------------
// gamma_color_ramp_generator_top_tb
// Self-checking bench for the gamma-corrected color ramp generator. Requests
// go in on the slave stream with bursty timing. Every color-map beat on the
// master stream is compared against a bit-exact fixed-point prediction of the
// ramp (log2, scaling and exp2 in Q16, blend per component). The ramp end
// colors are rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gamma_color_ramp_generator_top_tb;

	localparam int FRAC      = 16;
	localparam int IDX_BITS  = 12;
	localparam int MAX_RAMP  = 64;
	localparam int S_WIDTH   = 40;
	localparam int M_WIDTH   = 40;
	localparam int IDLE_LIMIT = 8000;
	localparam int SETTLE    = 120;
	// register indexes outside the list, ignored by the block
	localparam logic [gcr_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_A = 3'd6;
	localparam logic [gcr_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_B = 3'd7;

	typedef struct {
		logic [IDX_BITS-1:0]           map_index;
		logic [gcr_pkg::COMP_BITS-1:0] red;
		logic [gcr_pkg::COMP_BITS-1:0] green;
		logic [gcr_pkg::COMP_BITS-1:0] blue;
		logic                          last;
	} map_write_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [S_WIDTH-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [M_WIDTH-1:0] m_tdata;
	logic m_tlast;
	logic cfg_valid;
	logic cfg_ready;
	logic [gcr_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [gcr_pkg::COMP_BITS-1:0] cfg_data;

	// color registers as the bench believes them
	logic [gcr_pkg::COMP_BITS-1:0] color_regs [0:5];
	logic [63:0] half_roots [1:FRAC];

	map_write_t pending_writes [$];
	int mismatches;
	int requests_sent;
	int beats_checked;
	int cfg_writes;
	int burst_left;
	int hold_request;
	int hold_cnt;
	int idle_cycles;
	logic [7:0] stall_pattern;
	int pattern_age;

	gamma_color_ramp_generator_top uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// ---------------- prediction ----------------

	function automatic logic [63:0] floor_sqrt(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		v = val;
		res = '0;
		bt = 64'd1 << 62;
		while (bt > v && bt != 0) bt = bt >> 2;
		while (bt != 0) begin
			if (v >= res + bt) begin
				v = v - (res + bt);
				res = (res >> 1) + bt;
			end else begin
				res = res >> 1;
			end
			bt = bt >> 2;
		end
		return res;
	endfunction

	// log2 in Q16 by repeated squaring of the mantissa
	function automatic logic [63:0] log2_q16(input logic [31:0] x);
		int e;
		logic [63:0] m;
		logic [63:0] acc;
		e = 0;
		while ((x >> (e + 1)) != 0) e++;
		m = ({32'd0, x} << FRAC) >> e;
		acc = 64'(e) << FRAC;
		for (int k = FRAC - 1; k >= 0; k--) begin
			m = (m * m) >> FRAC;
			if (m >= (64'd2 << FRAC)) begin
				acc[k] = 1'b1;
				m = m >> 1;
			end
		end
		return acc;
	endfunction

	// 2^-p with p in Q16, result in Q16
	function automatic logic [63:0] exp2_neg_q16(input logic [63:0] p);
		logic [63:0] q;
		logic [63:0] acc;
		q = p >> FRAC;
		acc = 64'd1 << 32;
		if (q > 32) return 64'd0;
		for (int k = 1; k <= FRAC; k++)
			if (p[FRAC - k]) acc = (acc * half_roots[k]) >> 32;
		acc = acc >> q;
		return acc >> (32 - FRAC);
	endfunction

	function automatic logic [gcr_pkg::COMP_BITS-1:0] shade(input logic [7:0] dark,
			input logic [7:0] bright, input logic [63:0] y);
		logic [63:0] span;
		if (bright >= dark) begin
			span = (y * 64'(bright - dark)) >> FRAC;
			return 8'(64'(dark) + span);
		end
		span = (y * 64'(dark - bright) + ((64'd1 << FRAC) - 1)) >> FRAC;
		return 8'(64'(dark) - span);
	endfunction

	// expected color-map writes of one request
	task automatic queue_ramp(input logic [15:0] gamma, input logic [11:0] base,
			input logic [6:0] count_in);
		logic [63:0] g;
		logic [63:0] inv;
		logic [63:0] logn;
		logic [63:0] y;
		int n;
		map_write_t w;
		g = (gamma < gcr_pkg::GAMMA_FLOOR) ? 64'(gcr_pkg::GAMMA_FLOOR) : 64'(gamma);
		inv = (64'd4096 << FRAC) / g;
		if (inv > ((64'd1 << (FRAC + 4)) - 1)) inv = (64'd1 << (FRAC + 4)) - 1;
		n = (count_in > MAX_RAMP) ? MAX_RAMP : int'(count_in);
		logn = (n >= 2) ? log2_q16(32'(n - 1)) : 64'd0;
		for (int i = 0; i < n; i++) begin
			y = 64'd0;
			if (i != 0) y = exp2_neg_q16(((logn - log2_q16(32'(i))) * inv) >> FRAC);
			w.map_index = IDX_BITS'(base + i);
			w.red   = shade(color_regs[gcr_pkg::REG_DARK_RED],
				color_regs[gcr_pkg::REG_BRIGHT_RED], y);
			w.green = shade(color_regs[gcr_pkg::REG_DARK_GREEN],
				color_regs[gcr_pkg::REG_BRIGHT_GREEN], y);
			w.blue  = shade(color_regs[gcr_pkg::REG_DARK_BLUE],
				color_regs[gcr_pkg::REG_BRIGHT_BLUE], y);
			w.last  = (i + 1 == n);
			pending_writes.push_back(w);
		end
	endtask

	// ---------------- drivers ----------------

	// one request beat; bursts of random length with random gaps
	task automatic send_request(input logic [15:0] gamma, input logic [11:0] base,
			input logic [6:0] count_in);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, count_in, base, gamma};
		do @(posedge clk); while (!s_tready);
		queue_ramp(gamma, base, count_in);
		requests_sent++;
	endtask

	// lower the request stream and wait out every pending write
	task automatic drain;
		s_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_writes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gcr_pkg::CFG_INDEX_BITS-1:0] idx,
			input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		if (idx <= gcr_pkg::REG_DARK_BLUE) color_regs[idx] = val;
		cfg_writes++;
	endtask

	task automatic set_colors(input logic [7:0] br, input logic [7:0] bg,
			input logic [7:0] bb, input logic [7:0] dr, input logic [7:0] dg,
			input logic [7:0] db);
		write_reg(gcr_pkg::REG_BRIGHT_RED, br);
		write_reg(gcr_pkg::REG_BRIGHT_GREEN, bg);
		write_reg(gcr_pkg::REG_BRIGHT_BLUE, bb);
		write_reg(gcr_pkg::REG_DARK_RED, dr);
		write_reg(gcr_pkg::REG_DARK_GREEN, dg);
		write_reg(gcr_pkg::REG_DARK_BLUE, db);
	endtask

	// ---------------- receiver and checker ----------------

	always @(posedge clk) begin
		map_write_t w;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_writes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: idx %0d rgb %0d %0d %0d last %0d",
						m_tdata[11:0], m_tdata[19:12], m_tdata[27:20], m_tdata[35:28],
						m_tlast);
			end else begin
				w = pending_writes.pop_front();
				beats_checked++;
				if (m_tdata[11:0] !== w.map_index || m_tdata[19:12] !== w.red ||
						m_tdata[27:20] !== w.green || m_tdata[35:28] !== w.blue ||
						m_tlast !== w.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: exp idx %0d rgb %0d %0d %0d last %0d,",
							" got idx %0d rgb %0d %0d %0d last %0d"},
							w.map_index, w.red, w.green, w.blue, w.last,
							m_tdata[11:0], m_tdata[19:12], m_tdata[27:20],
							m_tdata[35:28], m_tlast);
				end
			end
		end
		// stall pattern, refreshed now and then; long hold-off on request
		if (hold_request > 0) begin
			hold_cnt = hold_request;
			hold_request = 0;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_tready <= 1'b0;
		end else begin
			pattern_age++;
			if (pattern_age >= 64) begin
				pattern_age = 0;
				stall_pattern = ($urandom_range(0, 2) == 0) ? 8'hFF : 8'($urandom);
				if (stall_pattern == 8'h00) stall_pattern = 8'h01;
			end
			stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
			m_tready <= stall_pattern[0];
		end
	end

	// watchdog on cycles without any accepted beat
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout after %0d idle cycles", idle_cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ---------------- tests ----------------

	// field extremes and special cases at reset colors
	task automatic test_directed;
		send_request(16'd4096, 12'd0, 7'd0);      // zero count
		send_request(16'd4096, 12'd17, 7'd1);     // single entry
		send_request(16'd4096, 12'd100, 7'd2);
		send_request(16'd0, 12'd4095, 7'd5);      // small gamma, wraps
		send_request(16'd204, 12'd300, 7'd9);
		send_request(16'd205, 12'd301, 7'd9);
		send_request(16'd65535, 12'd2048, 7'd16); // largest gamma
		send_request(16'd8192, 12'd4090, 7'd12);  // index wraps
		send_request(16'd2048, 12'd1365, 7'd64);  // full ramp
		send_request(16'd4096, 12'd2730, 7'd65);  // saturated count
		send_request(16'd1000, 12'd3000, 7'd127);
		send_request(16'hAAAA, 12'hAAA, 7'd3);
		send_request(16'h5555, 12'h555, 7'd4);
		drain();
	endtask

	// every register, extremes, inverted ramps and ignored indexes
	task automatic test_colors;
		set_colors(8'd255, 8'd0, 8'd128, 8'd0, 8'd255, 8'd128);
		send_request(16'd4096, 12'd10, 7'd8);
		send_request(16'd1500, 12'd20, 7'd6);
		drain();
		set_colors(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
		write_reg(REG_SPARE_A, 8'h5A);
		write_reg(REG_SPARE_B, 8'hA5);
		send_request(16'd3000, 12'd40, 7'd10);
		send_request(16'd12000, 12'd50, 7'd7);
		drain();
		set_colors(8'd77, 8'd77, 8'd77, 8'd77, 8'd77, 8'd77);
		send_request(16'd4096, 12'd60, 7'd5);
		drain();
	endtask

	// output held off long enough to fill the block, then a full pause
	task automatic test_backpressure;
		set_colors(8'd200, 8'd30, 8'd255, 8'd10, 8'd220, 8'd0);
		hold_request = 500;
		for (int i = 0; i < 8; i++)
			send_request(16'($urandom), 12'($urandom), 7'($urandom_range(1, 6)));
		drain();
	endtask

	task automatic test_random;
		logic [15:0] gamma;
		logic [6:0] count_in;
		for (int i = 0; i < 284; i++) begin
			if (i % 65 == 64) begin
				drain();
				set_colors(8'($urandom), 8'($urandom), 8'($urandom),
					8'($urandom), 8'($urandom), 8'($urandom));
			end
			case ($urandom_range(0, 3))
				0: gamma = 16'($urandom);
				1: gamma = 16'($urandom_range(0, 400));
				default: gamma = 16'($urandom_range(1024, 16384));
			endcase
			if ($urandom_range(0, 49) == 0)
				count_in = 7'($urandom_range(64, 127));
			else if ($urandom_range(0, 9) == 0)
				count_in = 7'($urandom_range(0, 1));
			else
				count_in = 7'($urandom_range(2, 10));
			send_request(gamma, 12'($urandom), count_in);
		end
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		mismatches = 0;
		requests_sent = 0;
		beats_checked = 0;
		cfg_writes = 0;
		burst_left = 0;
		hold_request = 0;
		hold_cnt = 0;
		idle_cycles = 0;
		stall_pattern = 8'hFF;
		pattern_age = 0;
		color_regs[gcr_pkg::REG_BRIGHT_RED] = 8'd255;
		color_regs[gcr_pkg::REG_BRIGHT_GREEN] = 8'd255;
		color_regs[gcr_pkg::REG_BRIGHT_BLUE] = 8'd255;
		color_regs[gcr_pkg::REG_DARK_RED] = 8'd0;
		color_regs[gcr_pkg::REG_DARK_GREEN] = 8'd0;
		color_regs[gcr_pkg::REG_DARK_BLUE] = 8'd0;
		half_roots[1] = floor_sqrt(64'd1 << 63);
		for (int k = 2; k <= FRAC; k++) half_roots[k] = floor_sqrt(half_roots[k - 1] << 32);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_colors();
		test_backpressure();
		test_random();

		mismatches += pending_writes.size();
		$display("covered %0d requests, %0d color-map beats, %0d register writes",
			requests_sent, beats_checked, cfg_writes);
		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
